// ===== hw/rtl/neighbourhood_blend_filter_macros.svh =====
// Assertion macros for the neighbourhood blend filter.
`ifndef NEIGHBOURHOOD_BLEND_FILTER_MACROS_SVH
`define NEIGHBOURHOOD_BLEND_FILTER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define NBF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define NBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/nbf_pkg.sv =====
// Types, constants and reciprocal table for the neighbourhood blend filter.
package nbf_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT + 2);
    localparam int FWIDTH_W     = 11;
    localparam int FHEIGHT_W    = 13;
    localparam int PIX_W        = 32;
    localparam int TAPS         = 9;
    localparam int STEP_W       = 4;
    localparam int NUM_W        = 12;
    localparam int RECIP_W      = 23;
    localparam int RECIP_SHIFT  = 24;
    localparam int ADDR_W       = 4;
    localparam int IDX_W        = 2;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_BORDER = 2'd2;

    localparam logic [FWIDTH_W-1:0]  WIDTH_RST  = 11'd1024;
    localparam logic [FHEIGHT_W-1:0] HEIGHT_RST = 13'd768;
    localparam logic [PIX_W-1:0]     BORDER_RST = 32'hFF00_0000;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0] color;
        logic             last;
    } t_out_word;

    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic [PIX_W-1:0]           acc;
        logic [TAPS-1:0][PIX_W-1:0] nb;
    } t_stage;

    // ceil(2^24 / (k + 3)) for blend step k + 1
    function automatic logic [RECIP_W-1:0] recip(input logic [STEP_W-1:0] k);
        logic [RECIP_W-1:0] m;
        unique case (k)
            4'd0:    m = 23'd5592406;
            4'd1:    m = 23'd4194304;
            4'd2:    m = 23'd3355444;
            4'd3:    m = 23'd2796203;
            4'd4:    m = 23'd2396746;
            4'd5:    m = 23'd2097152;
            4'd6:    m = 23'd1864136;
            4'd7:    m = 23'd1677722;
            4'd8:    m = 23'd1525202;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/neighbourhood_blend_filter.sv =====
// Top level of the streaming 3x3 neighbourhood blend filter.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+--------------------
//  in      | input     | i_valid / o_stall  | i_data (op, pixel)
//  out     | output    | o_valid / i_stall  | o_data (color, last)
//  config  | input     | APB psel / penable | pwdata / prdata
//
// One word per cycle in while the output is not stalled; a result for its completing word
// leaves through the line memory read register and then the chain of nine blend cells.
// Reset clears counters, window, valid bits and registers; line memory is not cleared.
// A stalled output holds the whole pipeline and raises o_stall.
`include "neighbourhood_blend_filter_macros.svh"

module neighbourhood_blend_filter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  nbf_pkg::t_in_word            i_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output nbf_pkg::t_out_word           o_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nbf_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import nbf_pkg::*;

    logic [FWIDTH_W-1:0]        r_frame_width;
    logic [FHEIGHT_W-1:0]       r_frame_height;
    logic [PIX_W-1:0]           r_border;
    logic [COL_W:0]             eff_w;
    logic [ROW_W-1:0]           eff_h;
    logic [IDX_W-1:0]           cfg_idx;
    logic                       cfg_wr;
    logic                       geom_wr;

    logic [COL_W-1:0]           r_col;
    logic [ROW_W-1:0]           r_row;
    logic [COL_W-1:0]           n_col;
    logic [ROW_W-1:0]           n_row;

    logic                       adv;
    logic                       acc_in;
    logic                       in_frame;
    logic                       take;
    logic                       col_zero;
    logic [COL_W:0]             w_m1;
    logic [COL_W:0]             cx;
    logic [ROW_W-1:0]           cy;
    logic                       emit;
    logic                       lf_out;
    logic                       rt_out;
    logic                       up_out;
    logic                       dn_out;
    logic                       a_last;
    logic [COL_W:0]             col_p1;
    logic [PIX_W-1:0]           a_pix;
    logic                       a_byp;

    logic                       r_b_valid;
    logic                       r_b_emit;
    logic                       r_b_last;
    logic                       r_b_sel;
    logic                       r_b_lf;
    logic                       r_b_rt;
    logic                       r_b_up;
    logic                       r_b_dn;
    logic [COL_W-1:0]           r_b_addr;
    logic [PIX_W-1:0]           r_b_pix;
    logic                       r_b_byp;
    logic [2*PIX_W-1:0]         r_b_byp_data;

    logic [2*PIX_W-1:0]         rdata;
    logic [2*PIX_W-1:0]         line;
    logic [PIX_W-1:0]           b_top;
    logic [PIX_W-1:0]           b_mid;
    logic [TAPS-1:0][PIX_W-1:0] r_win;
    logic [TAPS-1:0][PIX_W-1:0] n_win;
    logic [TAPS-1:0][PIX_W-1:0] cells;
    logic [TAPS-1:0][PIX_W-1:0] nb;
    logic [PIX_W-1:0]           c_left;
    logic [PIX_W-1:0]           c_centre;
    logic [PIX_W-1:0]           c_up;
    logic [PIX_W-1:0]           c_down;
    logic [PIX_W-1:0]           c_upleft;
    logic [PIX_W-1:0]           c_downleft;
    t_stage                     stage [TAPS+1];

    // configuration
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign geom_wr = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RST;
            r_frame_height <= HEIGHT_RST;
            r_border       <= BORDER_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WIDTH:  r_frame_width  <= pwdata[FWIDTH_W-1:0];
                REG_HEIGHT: r_frame_height <= pwdata[FHEIGHT_W-1:0];
                REG_BORDER: r_border       <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WIDTH:  prdata = 32'(r_frame_width);
            REG_HEIGHT: prdata = 32'(r_frame_height);
            REG_BORDER: prdata = r_border;
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        priority if (r_frame_width == '0) begin
            eff_w = (COL_W + 1)'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            eff_w = (COL_W + 1)'(MAX_WIDTH);
        end else begin
            eff_w = (COL_W + 1)'(r_frame_width);
        end
        priority if (r_frame_height == '0) begin
            eff_h = ROW_W'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            eff_h = ROW_W'(MAX_HEIGHT);
        end else begin
            eff_h = ROW_W'(r_frame_height);
        end
    end

    // handshake
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;
    assign acc_in  = i_valid && adv;

    // position of the completed centre
    always_comb begin
        in_frame = r_row < eff_h;
        take     = acc_in && !(in_frame && i_data.op);
        col_zero = r_col == '0;
        w_m1     = eff_w - (COL_W + 1)'(1);
        if (col_zero) begin
            cx   = w_m1;
            cy   = r_row - ROW_W'(2);
            emit = (r_row >= ROW_W'(2)) && (r_row <= eff_h + ROW_W'(1));
        end else begin
            cx   = (COL_W + 1)'(r_col) - (COL_W + 1)'(1);
            cy   = r_row - ROW_W'(1);
            emit = (r_row >= ROW_W'(1)) && (r_row <= eff_h);
        end
        lf_out = cx == '0;
        rt_out = cx == w_m1;
        up_out = cy == '0;
        dn_out = cy == eff_h - ROW_W'(1);
        a_last = emit && rt_out && dn_out;
        a_pix  = in_frame ? i_data.pixel : r_border;
        a_byp  = r_b_valid && (r_b_addr == r_col);

        col_p1 = (COL_W + 1)'(r_col) + (COL_W + 1)'(1);
        if (a_last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_p1 >= eff_w) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = col_p1[COL_W-1:0];
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (geom_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (take) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_emit     <= emit;
            r_b_last     <= a_last;
            r_b_sel      <= col_zero;
            r_b_lf       <= lf_out;
            r_b_rt       <= rt_out;
            r_b_up       <= up_out;
            r_b_dn       <= dn_out;
            r_b_addr     <= r_col;
            r_b_pix      <= a_pix;
            r_b_byp      <= a_byp;
            r_b_byp_data <= {b_mid, r_b_pix};
        end
    end

    // line memory: each entry holds {two lines up, one line up}
    nbf_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_b_valid && adv),
        .i_waddr (r_b_addr),
        .i_wdata ({b_mid, r_b_pix}),
        .i_re    (adv),
        .i_raddr (r_col),
        .o_rdata (rdata)
    );

    // window shift and neighbour selection
    always_comb begin
        line  = r_b_byp ? r_b_byp_data : rdata;
        b_top = line[2*PIX_W-1:PIX_W];
        b_mid = line[PIX_W-1:0];
        for (int r = 0; r < 3; r++) begin
            n_win[3*r]     = r_win[3*r + 1];
            n_win[3*r + 1] = r_win[3*r + 2];
        end
        n_win[2] = b_top;
        n_win[5] = b_mid;
        n_win[8] = r_b_pix;
        cells    = r_b_sel ? r_win : n_win;

        c_left     = r_b_sel ? cells[4] : cells[3];
        c_centre   = r_b_sel ? cells[5] : cells[4];
        c_up       = r_b_sel ? cells[2] : cells[1];
        c_down     = r_b_sel ? cells[8] : cells[7];
        c_upleft   = r_b_sel ? cells[1] : cells[0];
        c_downleft = r_b_sel ? cells[7] : cells[6];

        nb[0] = r_b_lf ? r_border : c_left;
        nb[1] = r_b_up ? r_border : c_up;
        nb[2] = r_b_rt ? r_border : cells[5];
        nb[3] = r_b_dn ? r_border : c_down;
        nb[4] = (r_b_lf || r_b_up) ? r_border : c_upleft;
        nb[5] = (r_b_rt || r_b_up) ? r_border : cells[2];
        nb[6] = (r_b_rt || r_b_dn) ? r_border : cells[8];
        nb[7] = (r_b_lf || r_b_dn) ? r_border : c_downleft;
        nb[8] = c_centre;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_b_valid && adv) begin
            r_win <= n_win;
        end
    end

    // blend chain
    assign stage[0] = '{valid: r_b_valid && r_b_emit, last: r_b_last, acc: '0, nb: nb};

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        nbf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_step  (STEP_W'(k)),
            .i_stage (stage[k]),
            .o_stage (stage[k+1])
        );
    end

    assign o_valid      = stage[TAPS].valid;
    assign o_data.color = stage[TAPS].acc;
    assign o_data.last  = stage[TAPS].last;

    `NBF_ASSERT_IMPL(a_col_range, i_clk, i_rst_n, 1'b1, (COL_W + 1)'(r_col) < eff_w, "column beyond width")
    `NBF_ASSERT_IMPL(a_row_range, i_clk, i_rst_n, 1'b1, r_row <= eff_h + ROW_W'(1), "row beyond drain")
    `NBF_ASSERT_NEXT(a_last_wrap, i_clk, i_rst_n, take && a_last, r_col == '0 && r_row == '0, "no wrap at frame end")

endmodule

// ===== hw/rtl/nbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module nbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/nbf_cell.sv =====
// One blend step cell: folds one neighbour into the running accumulator.
module nbf_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic [nbf_pkg::STEP_W-1:0]  i_step,
    input  nbf_pkg::t_stage             i_stage,
    output nbf_pkg::t_stage             o_stage
);
    import nbf_pkg::*;

    logic [PIX_W-1:0]                   nb;
    logic [RECIP_W-1:0]                 m;
    logic [3:0][NUM_W-1:0]              num;
    logic [3:0][NUM_W+RECIP_W-1:0]      prod;
    logic [PIX_W-1:0]                   n_acc;
    logic                               r_valid;
    logic                               r_last;
    logic [PIX_W-1:0]                   r_acc;
    logic [TAPS-1:0][PIX_W-1:0]         r_nb;

    always_comb begin
        nb = i_stage.nb[i_step];
        m  = recip(i_step);
        for (int b = 0; b < 4; b++) begin
            num[b]  = NUM_W'(i_stage.acc[8*b +: 8]) * NUM_W'(i_step + STEP_W'(1))
                    + NUM_W'({nb[8*b +: 8], 1'b0});
            prod[b] = (NUM_W + RECIP_W)'(num[b]) * (NUM_W + RECIP_W)'(m);
            n_acc[8*b +: 8] = prod[b][RECIP_SHIFT +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_last <= i_stage.last;
            r_acc  <= n_acc;
            r_nb   <= i_stage.nb;
        end
    end

    assign o_stage = '{valid: r_valid, last: r_last, acc: r_acc, nb: r_nb};

endmodule
